// ===== src/mesh_segment_reassembler_core_assert.svh =====
// Assertion macros used by the checker file of the segment reassembler.
`ifndef MESH_SEGMENT_REASSEMBLER_CORE_ASSERT_SVH
`define MESH_SEGMENT_REASSEMBLER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MSR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("reassembler check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define MSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("reassembler check failed");

`endif

// ===== src/msr_pkg.sv =====
// Types and constants shared by the segment reassembler modules.
package msr_pkg;

	localparam logic       KIND_ACK     = 1'b0;
	localparam logic       KIND_DATA    = 1'b1;
	localparam logic       REG_OWN_ADDR = 1'b0;
	localparam logic [4:0] POS_MAX      = 5'd31;
	localparam logic [4:0] POS_STORE_END = 5'd30;
	localparam logic [4:0] POS_HDR_END  = 5'd3;
	localparam logic [4:0] POS_PAYLOAD  = 5'd4;
	localparam logic [4:0] SHORT_BYTES  = 5'd16;
	localparam logic [23:0] SEQ_HI_STEP = 24'h002000;
	localparam logic [3:0] WORD_BYTES   = 4'd8;

	typedef struct packed {
		logic accept;
		logic clr_step;
		logic fstart;
		logic fetch;
		logic load_ack;
		logic load_word;
	} cmd_t;

	typedef struct packed {
		logic new_ctx;
		logic emit_seg;
		logic emit_short;
		logic clr_done;
		logic fetch_done;
		logic more;
	} sts_t;

endpackage

// ===== src/msr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module msr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/msr_ctrl.sv =====
// Controller state machine: clearing pass, byte intake and result sequencing.
module msr_ctrl import msr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ACK,
		S_FETCH,
		S_SHOW
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   accept;

	assign accept = (state_q == S_IDLE) && in_valid;

	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.clr_step  = (state_q == S_CLEAR);
		cmd.fetch     = (state_q == S_FETCH);
		cmd.load_ack  = accept && !sts.new_ctx && sts.emit_seg;
		cmd.load_word = (state_q == S_FETCH) && sts.fetch_done;
		cmd.fstart    = (accept && !sts.new_ctx && !sts.emit_seg && sts.emit_short)
			|| ((state_q == S_ACK) && out_ready)
			|| ((state_q == S_SHOW) && out_ready && sts.more);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clr_done) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						if (sts.new_ctx) begin
							state_q    <= S_CLEAR;
							in_ready_q <= 1'b0;
						end else if (sts.emit_seg) begin
							state_q     <= S_ACK;
							in_ready_q  <= 1'b0;
							out_valid_q <= 1'b1;
						end else if (sts.emit_short) begin
							state_q    <= S_FETCH;
							in_ready_q <= 1'b0;
						end
					end
				end
				S_ACK: begin
					if (out_ready) begin
						state_q     <= S_FETCH;
						out_valid_q <= 1'b0;
					end
				end
				S_FETCH: begin
					if (sts.fetch_done) begin
						state_q     <= S_SHOW;
						out_valid_q <= 1'b1;
					end
				end
				S_SHOW: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (sts.more) begin
							state_q <= S_FETCH;
						end else begin
							state_q    <= S_IDLE;
							in_ready_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule

// ===== src/msr_dp.sv =====
// Datapath: PDU parsing, reassembly context, byte stores and word assembly.
module msr_dp import msr_pkg::*; #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [15:0] own_address,
	input  logic [7:0]  pdu_byte,
	input  logic        byte_last,
	input  logic [23:0] msg_seq,
	input  logic [15:0] msg_src,
	input  logic [15:0] msg_dst,
	input  logic        msg_ctl,
	output logic        kind,
	output logic [63:0] data_word,
	output logic [3:0]  word_bytes,
	output logic        key_is_app,
	output logic        mic_is_long,
	output logic [23:0] nonce_seq,
	output logic [15:0] source_addr,
	output logic [12:0] ack_seqzero,
	output logic [31:0] ack_block,
	output logic        last_of_run,
	output logic        overflowed
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam logic [9:0] BUF_LIM = 10'(BUFFER_BYTES);
	localparam logic [8:0] OUT_CAP = (BUFFER_BYTES < 256) ? 9'(BUFFER_BYTES) : 9'd256;
	localparam logic [AW-1:0] CLR_LAST = AW'(BUFFER_BYTES - 1);

	// Parser and context state.
	logic [4:0]  pos_q;
	logic [7:0]  lead_q;
	logic [23:0] hdr_q;
	logic        ctx_valid_q;
	logic [12:0] ctx_sz_q;
	logic [31:0] mask_q;
	logic [23:0] first_seq_q;
	logic        ctx_mic_q;
	logic [8:0]  total_q;
	logic [7:0]  short_mem_q [16];
	logic [AW-1:0] clr_q;

	// Emission state.
	logic        e_seg_q;
	logic [8:0]  e_len_q;
	logic [8:0]  e_off_q;
	logic        e_akf_q;
	logic        e_mic_q;
	logic [23:0] e_nseq_q;
	logic [15:0] e_src_q;
	logic        e_ovf_q;
	logic [3:0]  f_idx_q;
	logic        land_s1;
	logic [2:0]  land_idx_s1;
	logic [7:0]  short_s1;
	logic [63:0] word_q;

	logic        ok;
	logic [7:0]  lead_w;
	logic [23:0] hdr_w;
	logic        seg_w;
	logic        akf_w;
	logic        szmic_w;
	logic [12:0] sz_w;
	logic [4:0]  sego_w;
	logic [4:0]  segn_w;
	logic        new_ctx_w;
	logic [31:0] mask_base;
	logic [8:0]  total_base;
	logic [23:0] fs_base;
	logic        mic_base;
	logic        seg_last_w;
	logic [4:0]  seglen_w;
	logic [9:0]  sego12_w;
	logic [8:0]  total_new;
	logic [31:0] mask_new;
	logic [31:0] full_w;
	logic        complete_w;
	logic [23:0] sa0_w;
	logic [23:0] sa_w;
	logic [8:0]  seg_len_out;
	logic        seg_ovf;
	logic        short_emit;
	logic [8:0]  short_len;
	logic        short_ovf;
	logic [9:0]  st_addr;
	logic        st_we;
	logic        ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]  ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]  ram_rdata;
	logic [8:0]  rd_idx;
	logic [8:0]  rem_w;
	logic [3:0]  nb_w;
	logic        issue;
	logic [7:0]  land_byte;
	logic [4:0]  pos_next;

	assign ok     = !msg_ctl && (msg_dst == own_address);
	assign lead_w = (pos_q == 5'd0) ? pdu_byte : lead_q;
	assign hdr_w  = (pos_q != 5'd0 && pos_q <= POS_HDR_END) ? {hdr_q[15:0], pdu_byte} : hdr_q;
	assign seg_w  = lead_w[7];
	assign akf_w  = lead_w[6];
	assign szmic_w = hdr_w[23];
	assign sz_w   = hdr_w[22:10];
	assign sego_w = hdr_w[9:5];
	assign segn_w = hdr_w[4:0];

	assign new_ctx_w = ok && seg_w && (pos_q == POS_HDR_END)
		&& (!ctx_valid_q || (sz_w != ctx_sz_q));
	assign mask_base  = new_ctx_w ? 32'd0 : mask_q;
	assign total_base = new_ctx_w ? 9'd0 : total_q;
	assign fs_base    = new_ctx_w ? msg_seq : first_seq_q;
	assign mic_base   = new_ctx_w ? szmic_w : ctx_mic_q;

	assign seg_last_w = ok && seg_w && byte_last && (pos_q >= POS_HDR_END);
	assign seglen_w   = ((pos_q > POS_STORE_END) ? POS_STORE_END : pos_q) - POS_HDR_END;
	// Segment offset times twelve, as a sum of two shifts.
	assign sego12_w   = 10'({sego_w, 3'b000}) + 10'({sego_w, 2'b00});
	assign total_new  = (sego_w == segn_w) ? 9'(sego12_w + 10'(seglen_w)) : total_base;
	assign mask_new   = mask_base | (32'd1 << sego_w);
	// Shifting past bit 31 wraps to zero, so SegN of 31 yields an all-ones mask.
	assign full_w     = (32'd2 << segn_w) - 32'd1;
	assign complete_w = seg_last_w && ((mask_new & full_w) == full_w) && (total_new != 9'd0);

	assign sa0_w = {fs_base[23:13], sz_w};
	assign sa_w  = (fs_base[12:0] < sz_w) ? (sa0_w - SEQ_HI_STEP) : sa0_w;
	assign seg_ovf     = total_new > OUT_CAP;
	assign seg_len_out = seg_ovf ? OUT_CAP : total_new;

	assign short_emit = ok && !seg_w && byte_last;
	assign short_ovf  = pos_q > SHORT_BYTES;
	assign short_len  = short_ovf ? 9'(SHORT_BYTES) : 9'(pos_q);

	assign st_addr = sego12_w + 10'(pos_q) - 10'(POS_PAYLOAD);
	assign st_we   = cmd.accept && ok && seg_w && (pos_q >= POS_PAYLOAD)
		&& (pos_q < POS_MAX) && (st_addr < BUF_LIM);

	assign pos_next = byte_last ? 5'd0 : ((pos_q == POS_MAX) ? POS_MAX : pos_q + 5'd1);

	assign ram_we    = st_we || cmd.clr_step;
	assign ram_waddr = cmd.clr_step ? clr_q : st_addr[AW-1:0];
	assign ram_wdata = cmd.clr_step ? 8'd0 : pdu_byte;

	assign rd_idx    = e_off_q + 9'(f_idx_q);
	assign ram_raddr = rd_idx[AW-1:0];
	assign rem_w     = e_len_q - e_off_q;
	assign nb_w      = (rem_w > 9'(WORD_BYTES)) ? WORD_BYTES : rem_w[3:0];
	assign issue     = cmd.fetch && (f_idx_q != nb_w);
	assign land_byte = e_seg_q ? ram_rdata : short_s1;

	msr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		sts            = '0;
		sts.new_ctx    = new_ctx_w;
		sts.emit_seg   = complete_w;
		sts.emit_short = short_emit;
		sts.clr_done   = (clr_q == CLR_LAST);
		sts.fetch_done = (f_idx_q == nb_w) && !land_s1;
		sts.more       = e_off_q < e_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			lead_q      <= '0;
			hdr_q       <= '0;
			ctx_valid_q <= 1'b0;
			ctx_sz_q    <= '0;
			mask_q      <= '0;
			first_seq_q <= '0;
			ctx_mic_q   <= 1'b0;
			total_q     <= '0;
			clr_q       <= '0;
			f_idx_q     <= '0;
			land_s1     <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= (clr_q == CLR_LAST) ? '0 : clr_q + AW'(1);
			end
			if (cmd.accept) begin
				pos_q  <= pos_next;
				lead_q <= lead_w;
				hdr_q  <= hdr_w;
				if (new_ctx_w) begin
					ctx_valid_q <= 1'b1;
					ctx_sz_q    <= sz_w;
					first_seq_q <= msg_seq;
					ctx_mic_q   <= szmic_w;
					mask_q      <= '0;
					total_q     <= '0;
				end
				if (seg_last_w) begin
					mask_q  <= mask_new;
					total_q <= total_new;
					if (complete_w) begin
						ctx_valid_q <= 1'b0;
					end
				end
			end
			if (cmd.fstart) begin
				f_idx_q <= '0;
			end else if (issue) begin
				f_idx_q <= f_idx_q + 4'd1;
			end
			land_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && ok && !seg_w && (pos_q != 5'd0) && (pos_q <= SHORT_BYTES)) begin
			short_mem_q[4'(pos_q - 5'd1)] <= pdu_byte;
		end
		if (issue) begin
			short_s1    <= short_mem_q[rd_idx[3:0]];
			land_idx_s1 <= f_idx_q[2:0];
		end
		if (cmd.fstart) begin
			word_q <= '0;
		end else if (land_s1) begin
			word_q[{land_idx_s1, 3'b000} +: 8] <= land_byte;
		end
		if (cmd.accept && complete_w) begin
			e_seg_q  <= 1'b1;
			e_len_q  <= seg_len_out;
			e_off_q  <= '0;
			e_akf_q  <= akf_w;
			e_mic_q  <= mic_base;
			e_nseq_q <= sa_w;
			e_src_q  <= msg_src;
			e_ovf_q  <= seg_ovf;
		end else if (cmd.accept && short_emit) begin
			e_seg_q  <= 1'b0;
			e_len_q  <= short_len;
			e_off_q  <= '0;
			e_akf_q  <= akf_w;
			e_mic_q  <= 1'b0;
			e_nseq_q <= msg_seq;
			e_src_q  <= msg_src;
			e_ovf_q  <= short_ovf;
		end else if (cmd.load_word) begin
			e_off_q <= e_off_q + 9'(nb_w);
		end
		if (cmd.load_ack) begin
			kind        <= KIND_ACK;
			data_word   <= '0;
			word_bytes  <= '0;
			key_is_app  <= akf_w;
			mic_is_long <= mic_base;
			nonce_seq   <= sa_w;
			source_addr <= msg_src;
			ack_seqzero <= sz_w;
			ack_block   <= mask_new;
			last_of_run <= 1'b0;
			overflowed  <= seg_ovf;
		end else if (cmd.load_word) begin
			kind        <= KIND_DATA;
			data_word   <= word_q;
			word_bytes  <= nb_w;
			key_is_app  <= e_akf_q;
			mic_is_long <= e_mic_q;
			nonce_seq   <= e_nseq_q;
			source_addr <= e_src_q;
			ack_seqzero <= '0;
			ack_block   <= '0;
			last_of_run <= (e_off_q + 9'(nb_w)) >= e_len_q;
			overflowed  <= e_ovf_q;
		end
	end

endmodule

// ===== src/mesh_segment_reassembler_core.sv =====
// Top level of the mesh lower transport segment reassembler.
//
//   Channel   Handshake               Moves per beat
//   input     in_valid / in_ready     one PDU byte with its message fields
//   output    out_valid / out_ready   one acknowledgement or one data word
//   config    psel / penable / pwrite own_address at byte address 0
//
// A byte with no result or new context leaves intake open for the next byte in the cycle after it.
// A word is gathered byte by byte from the byte-wide store or short buffer into one output beat.
// A new reassembly context starts a clearing pass over all BUFFER_BYTES store entries with no intake.
// After reset the same clearing pass runs before the first byte is taken.
// While results are being delivered no input byte is taken.
module mesh_segment_reassembler_core import msr_pkg::*; #(
	parameter int BUFFER_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  pdu_byte,
	input  logic        byte_last,
	input  logic [23:0] msg_seq,
	input  logic [15:0] msg_src,
	input  logic [15:0] msg_dst,
	input  logic        msg_ctl,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [63:0] data_word,
	output logic [3:0]  word_bytes,
	output logic        key_is_app,
	output logic        mic_is_long,
	output logic [23:0] nonce_seq,
	output logic [15:0] source_addr,
	output logic [12:0] ack_seqzero,
	output logic [31:0] ack_block,
	output logic        last_of_run,
	output logic        overflowed
);

	logic [15:0] own_address_q;
	cmd_t        cmd;
	sts_t        sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= '0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_OWN_ADDR)) begin
			own_address_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_OWN_ADDR) ? {16'd0, own_address_q} : 32'd0;

	msr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msr_dp #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.own_address(own_address_q),
		.pdu_byte   (pdu_byte),
		.byte_last  (byte_last),
		.msg_seq    (msg_seq),
		.msg_src    (msg_src),
		.msg_dst    (msg_dst),
		.msg_ctl    (msg_ctl),
		.kind       (kind),
		.data_word  (data_word),
		.word_bytes (word_bytes),
		.key_is_app (key_is_app),
		.mic_is_long(mic_is_long),
		.nonce_seq  (nonce_seq),
		.source_addr(source_addr),
		.ack_seqzero(ack_seqzero),
		.ack_block  (ack_block),
		.last_of_run(last_of_run),
		.overflowed (overflowed)
	);

endmodule

// ===== src/msr_checker.sv =====
// Port-level checker for the reassembler, bound to the top level.
`include "mesh_segment_reassembler_core_assert.svh"

module msr_checker import msr_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [63:0] data_word,
	input logic [3:0]  word_bytes,
	input logic        last_of_run,
	input logic [31:0] ack_block
);

	// A stalled beat keeps its word.
	`MSR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(data_word))
	// An acknowledgement is always followed by at least one data word.
	`MSR_ASSERT_NOW(a_ack_not_last, out_valid && (kind == KIND_ACK), !last_of_run)
	`MSR_ASSERT_NOW(a_ack_empty, out_valid && (kind == KIND_ACK),
		(data_word == 64'd0) && (word_bytes == 4'd0))
	`MSR_ASSERT_NOW(a_word_shape, out_valid && (kind == KIND_DATA),
		(word_bytes <= 4'd8) && (ack_block == 32'd0))

endmodule

bind mesh_segment_reassembler_core msr_checker u_msr_checker (.*);

// ===== test/mesh_segment_reassembler_core_tb.sv =====
// Self-checking testbench for the mesh segment reassembler core.
module mesh_segment_reassembler_core_tb;
	import msr_pkg::*;

	localparam int STORE_BYTES = 256;
	localparam int LEN_CAP = (STORE_BYTES < 256) ? STORE_BYTES : 256;
	localparam int SEG_STRIDE = 12;
	localparam int ITEM_TARGET = 430;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic        kind;
		logic [63:0] data_word;
		logic [3:0]  word_bytes;
		logic        key_is_app;
		logic        mic_is_long;
		logic [23:0] nonce_seq;
		logic [15:0] source_addr;
		logic [12:0] ack_seqzero;
		logic [31:0] ack_block;
		logic        last_of_run;
		logic        overflowed;
	} result_t;

	// One directed message: lead byte, header bytes sent, payload length, filter, expected result count.
	typedef struct {
		logic [7:0]  lead;
		logic [23:0] hdr;
		int          hdr_bytes;
		int          plen;
		logic        ctl;
		logic        to_me;
		int          exp_results;
	} msg_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  pdu_byte;
	logic        byte_last;
	logic [23:0] msg_seq;
	logic [15:0] msg_src;
	logic [15:0] msg_dst;
	logic        msg_ctl;
	logic        out_valid;
	logic        out_ready;
	logic        kind;
	logic [63:0] data_word;
	logic [3:0]  word_bytes;
	logic        key_is_app;
	logic        mic_is_long;
	logic [23:0] nonce_seq;
	logic [15:0] source_addr;
	logic [12:0] ack_seqzero;
	logic [31:0] ack_block;
	logic        last_of_run;
	logic        overflowed;

	mesh_segment_reassembler_core u_top (.*);

	// Predictor state.
	logic [15:0] own_addr;
	logic        ctx_open;
	logic [12:0] ctx_seqzero;
	logic [31:0] seg_mask;
	logic [4:0]  ctx_final_seg;
	logic [23:0] ctx_first_seq;
	logic        ctx_long_mic;
	logic [8:0]  ctx_length;
	logic [7:0]  seg_store [STORE_BYTES];
	logic [7:0]  short_mem [16];
	logic [4:0]  byte_pos;
	logic [7:0]  lead_q;
	logic [23:0] hdr_q;

	result_t expected_beats[$];
	int      errors;
	int      items_sent;
	int      burst_left;
	logic    no_gaps;

	initial begin
		clk = 1'b0;
	end

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		errors++;
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	task automatic push_words(input logic [7:0] src_bytes [STORE_BYTES], input int len,
			input logic akf, input logic mic, input logic [23:0] nseq,
			input logic [15:0] src, input logic ovf, inout int n);
		result_t r;
		int off;
		int nb;
		r = '{default: '0};
		r.kind = KIND_DATA;
		r.key_is_app = akf;
		r.mic_is_long = mic;
		r.nonce_seq = nseq;
		r.source_addr = src;
		r.overflowed = ovf;
		if (len == 0) begin
			expected_beats.push_back(r);
			n++;
		end
		off = 0;
		while (off < len) begin
			nb = (len - off > 8) ? 8 : len - off;
			r.data_word = '0;
			for (int i = 0; i < nb; i++)
				r.data_word[8*i +: 8] = src_bytes[off + i];
			r.word_bytes = 4'(nb);
			expected_beats.push_back(r);
			n++;
			off += nb;
		end
	endtask

	// Works out the results caused by one accepted byte.
	task automatic predict_byte(input logic [7:0] b, input logic last,
			input logic [23:0] seq, input logic [15:0] src, input logic [15:0] dst,
			input logic ctl, output int n);
		logic [7:0]  tmp [STORE_BYTES];
		logic        ok;
		logic        akf;
		logic [12:0] sz;
		logic [4:0]  sego;
		logic [4:0]  segn;
		logic [31:0] full;
		logic [23:0] sa;
		int          pos;
		int          len;
		int          seglen;
		int          addr;
		result_t     r;
		n = 0;
		pos = byte_pos;
		ok = !ctl && (dst == own_addr);
		if (pos == 0) lead_q = b;
		else if (pos <= 3) hdr_q = {hdr_q[15:0], b};
		akf = lead_q[6];
		if (ok && !lead_q[7]) begin
			if (pos >= 1 && pos <= 16) short_mem[pos - 1] = b;
			if (last) begin
				for (int i = 0; i < 16; i++) tmp[i] = short_mem[i];
				len = (pos > 16) ? 16 : pos;
				push_words(tmp, len, akf, 1'b0, seq, src, pos > 16, n);
			end
		end else if (ok) begin
			sz = hdr_q[22:10];
			sego = hdr_q[9:5];
			segn = hdr_q[4:0];
			if (pos == 3 && (!ctx_open || sz != ctx_seqzero)) begin
				ctx_open = 1'b1;
				ctx_seqzero = sz;
				seg_mask = '0;
				ctx_final_seg = segn;
				ctx_first_seq = seq;
				ctx_long_mic = hdr_q[23];
				ctx_length = '0;
				for (int i = 0; i < STORE_BYTES; i++) seg_store[i] = '0;
			end
			if (pos >= 4 && pos < 31) begin
				addr = sego * SEG_STRIDE + pos - 4;
				if (addr < STORE_BYTES) seg_store[addr] = b;
			end
			if (last && pos >= 3) begin
				seglen = ((pos > 30) ? 30 : pos) - 3;
				full = (segn == 5'd31) ? 32'hFFFF_FFFF : ((32'd1 << (segn + 1)) - 32'd1);
				seg_mask[sego] = 1'b1;
				if (sego == segn) ctx_length = 9'(sego * SEG_STRIDE + seglen);
				if ((seg_mask & full) == full && ctx_length != 0) begin
					sa = {ctx_first_seq[23:13], sz};
					if (ctx_first_seq[12:0] < sz) sa = sa - SEQ_HI_STEP;
					len = (ctx_length > LEN_CAP) ? LEN_CAP : ctx_length;
					r = '{default: '0};
					r.kind = KIND_ACK;
					r.key_is_app = akf;
					r.mic_is_long = ctx_long_mic;
					r.nonce_seq = sa;
					r.source_addr = src;
					r.ack_seqzero = sz;
					r.ack_block = seg_mask;
					r.overflowed = ctx_length > LEN_CAP;
					expected_beats.push_back(r);
					n = 1;
					push_words(seg_store, len, akf, ctx_long_mic, sa, src,
						ctx_length > LEN_CAP, n);
					ctx_open = 1'b0;
				end
			end
		end
		if (last) byte_pos = '0;
		else if (pos < 31) byte_pos = 5'(pos + 1);
		if (n > 0) expected_beats[$].last_of_run = 1'b1;
	endtask

	// Output side: random stalls, with stretches of steady readiness, and a check of each beat.
	int stall_cycle;
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cycle <= 0;
		end else begin
			stall_cycle <= stall_cycle + 1;
			if ((stall_cycle / 300) % 3 == 0) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
			if (out_valid && out_ready) begin
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected beat", data_word, 0);
				end else begin
					e = expected_beats.pop_front();
					if (kind !== e.kind) report_mismatch("kind", kind, e.kind);
					if (data_word !== e.data_word)
						report_mismatch("data_word", data_word, e.data_word);
					if (word_bytes !== e.word_bytes)
						report_mismatch("word_bytes", word_bytes, e.word_bytes);
					if (key_is_app !== e.key_is_app)
						report_mismatch("key_is_app", key_is_app, e.key_is_app);
					if (mic_is_long !== e.mic_is_long)
						report_mismatch("mic_is_long", mic_is_long, e.mic_is_long);
					if (nonce_seq !== e.nonce_seq)
						report_mismatch("nonce_seq", nonce_seq, e.nonce_seq);
					if (source_addr !== e.source_addr)
						report_mismatch("source_addr", source_addr, e.source_addr);
					if (ack_seqzero !== e.ack_seqzero)
						report_mismatch("ack_seqzero", ack_seqzero, e.ack_seqzero);
					if (ack_block !== e.ack_block)
						report_mismatch("ack_block", ack_block, e.ack_block);
					if (last_of_run !== e.last_of_run)
						report_mismatch("last_of_run", last_of_run, e.last_of_run);
					if (overflowed !== e.overflowed)
						report_mismatch("overflowed", overflowed, e.overflowed);
				end
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last,
			input logic [23:0] seq, input logic [15:0] src, input logic [15:0] dst,
			input logic ctl, inout int n);
		int gap;
		int got;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		pdu_byte <= b;
		byte_last <= last;
		msg_seq <= seq;
		msg_src <= src;
		msg_dst <= dst;
		msg_ctl <= ctl;
		do @(posedge clk); while (!in_ready);
		predict_byte(b, last, seq, src, dst, ctl, got);
		n += got;
		items_sent++;
	endtask

	// Sends lead, hdr_bytes header bytes (most significant first), then payload.
	task automatic send_msg(input logic [7:0] lead, input logic [23:0] hdr,
			input int hdr_bytes, input int plen, input logic [23:0] seq,
			input logic [15:0] src, input logic [15:0] dst, input logic ctl,
			output int n);
		logic [7:0] bytes_q[$];
		n = 0;
		bytes_q.push_back(lead);
		for (int i = 0; i < hdr_bytes; i++) bytes_q.push_back(hdr[23 - 8*i -: 8]);
		for (int i = 0; i < plen; i++) bytes_q.push_back(8'($urandom));
		foreach (bytes_q[i])
			send_byte(bytes_q[i], i == bytes_q.size() - 1, seq, src, dst, ctl, n);
	endtask

	function automatic logic [15:0] dst_for(input logic to_me);
		return to_me ? own_addr : own_addr ^ 16'($urandom_range(1, 65535));
	endfunction

	// A well-formed segmented message in shuffled order, optionally with a
	// missing or repeated segment.
	task automatic seg_run(input int segn, input int fault, input int seg_len);
		int order[$];
		int n;
		int j;
		int tmp;
		int plen;
		logic [12:0] sz;
		logic        szmic;
		logic        akf;
		logic [23:0] seq;
		logic [15:0] src;
		sz = 13'($urandom);
		szmic = $urandom_range(0, 1);
		akf = $urandom_range(0, 1);
		seq = 24'($urandom);
		if ($urandom_range(0, 1)) seq[12:0] = 13'($urandom_range(0, 31));
		src = 16'($urandom);
		for (int i = 0; i <= segn; i++) order.push_back(i);
		for (int i = segn; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		if (fault == 1 && segn > 0) order.delete($urandom_range(0, segn));
		if (fault == 2) order.push_back(order[$urandom_range(0, segn)]);
		foreach (order[i]) begin
			plen = (order[i] == segn) ? $urandom_range(1, 27) : seg_len;
			send_msg({1'b1, akf, 6'($urandom)}, {szmic, sz, 5'(order[i]), 5'(segn)},
				3, plen, seq, src, own_addr, 1'b0, n);
			seq = seq + 24'($urandom_range(1, 3));
		end
	endtask

	task automatic wait_drained();
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_own_addr(input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_OWN_ADDR, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		own_addr = value;
	endtask

	msg_row_t directed [] = '{
		'{8'h00, 24'h0, 0, 0, 1'b0, 1'b1, 1},
		'{8'h7F, 24'h0, 0, 8, 1'b0, 1'b1, 1},
		'{8'h40, 24'h0, 0, 16, 1'b0, 1'b1, 2},
		'{8'h3C, 24'h0, 0, 17, 1'b0, 1'b1, 2},
		'{8'h00, 24'h0, 0, 3, 1'b1, 1'b1, 0},
		'{8'h00, 24'h0, 0, 3, 1'b0, 1'b0, 0},
		'{8'h80, 24'h0, 1, 0, 1'b0, 1'b1, 0},
		'{8'hC0, {1'b1, 13'h1FFF, 5'd0, 5'd0}, 3, 5, 1'b0, 1'b1, 2},
		'{8'h80, {1'b0, 13'h0001, 5'd0, 5'd0}, 3, 0, 1'b0, 1'b1, 0},
		'{8'h80, {1'b0, 13'h0001, 5'd0, 5'd0}, 3, 9, 1'b0, 1'b1, 3},
		'{8'hFF, {1'b0, 13'h0000, 5'd1, 5'd1}, 3, 4, 1'b0, 1'b1, 0},
		'{8'hFF, {1'b0, 13'h0000, 5'd0, 5'd1}, 3, 12, 1'b0, 1'b1, 3}
	};

	initial begin
		int n;
		int pick;
		logic [15:0] phase_addr [3];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		pdu_byte = '0;
		byte_last = 1'b0;
		msg_seq = '0;
		msg_src = '0;
		msg_dst = '0;
		msg_ctl = 1'b0;
		errors = 0;
		items_sent = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		own_addr = '0;
		ctx_open = 1'b0;
		ctx_seqzero = '0;
		seg_mask = '0;
		ctx_final_seg = '0;
		ctx_first_seq = '0;
		ctx_long_mic = 1'b0;
		ctx_length = '0;
		for (int i = 0; i < STORE_BYTES; i++) seg_store[i] = '0;
		for (int i = 0; i < 16; i++) short_mem[i] = '0;
		byte_pos = '0;
		lead_q = '0;
		hdr_q = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_own_addr(16'hFFFF);
		foreach (directed[i]) begin
			send_msg(directed[i].lead, directed[i].hdr, directed[i].hdr_bytes,
				directed[i].plen, 24'($urandom), 16'($urandom),
				dst_for(directed[i].to_me), directed[i].ctl, n);
			if (directed[i].exp_results >= 0 && n != directed[i].exp_results)
				report_mismatch("directed result count", n, directed[i].exp_results);
		end

		phase_addr[0] = 16'h0000;
		phase_addr[1] = 16'($urandom);
		phase_addr[2] = 16'hFFFF;
		for (int ph = 0; ph < 3; ph++) begin
			in_valid <= 1'b0;
			wait_drained();
			write_own_addr(phase_addr[ph]);
			no_gaps = (ph == 1);
			if (ph == 1) seg_run(20, 0, 1);
			while (items_sent < (ph + 1) * ITEM_TARGET / 3) begin
				pick = $urandom_range(0, 9);
				if (pick <= 4) begin
					seg_run($urandom_range(0, 3), 0, 12);
				end else if (pick == 5) begin
					send_msg(8'($urandom_range(0, 127)), 24'h0, 0, $urandom_range(0, 18),
						24'($urandom), 16'($urandom), own_addr, 1'b0, n);
				end else if (pick == 6) begin
					send_msg(8'($urandom_range(0, 127)), 24'h0, 0, $urandom_range(19, 36),
						24'($urandom), 16'($urandom), own_addr, 1'b0, n);
				end else if (pick == 7) begin
					send_msg(8'($urandom), 24'($urandom), 3, $urandom_range(0, 14),
						24'($urandom), 16'($urandom), dst_for($urandom_range(0, 1)),
						1'b1, n);
					send_msg(8'($urandom), 24'($urandom), 3, $urandom_range(0, 14),
						24'($urandom), 16'($urandom), dst_for(1'b0), 1'b0, n);
				end else if (pick == 8) begin
					send_msg(8'($urandom_range(128, 255)), 24'($urandom),
						$urandom_range(0, 2), 0, 24'($urandom), 16'($urandom),
						own_addr, 1'b0, n);
				end else begin
					seg_run($urandom_range(1, 4), $urandom_range(1, 2),
						$urandom_range(1, 27));
				end
				// Hold the sender until everything expected has come out.
				if (ph == 0 && items_sent > 200 && items_sent < 260) begin
					in_valid <= 1'b0;
					while (expected_beats.size() != 0) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;
		wait_drained();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
